@@ design/apdm_pkg.sv @@
package apdm_pkg;

  localparam int unsigned PatternLenDef = 32;
  localparam int unsigned MaxEditsDef   = 3;
  localparam int unsigned GroupDef      = 4;

  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned NumPatReg = 4;
  localparam int unsigned FlagsW    = 4;
  localparam int unsigned CodeW     = 2;

  localparam logic [CfgIdxW-1:0] RegPatternA = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatternB = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPatternC = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPatternD = 2'd3;

  // Control for one row unit in the current cycle.
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             base_valid;
    logic             update;
  } step_t;

endpackage

@@ design/apdm_row_unit.sv @@
module apdm_row_unit #(
  parameter int unsigned PATTERN_LEN = apdm_pkg::PatternLenDef,
  parameter int unsigned MAX_EDITS   = apdm_pkg::MaxEditsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  apdm_pkg::step_t                      step_i,
  input  logic [2*PATTERN_LEN-1:0]             pattern_i,
  output logic [MAX_EDITS:0]                   flags_o
);

  logic [PATTERN_LEN-1:0] rows_q [MAX_EDITS+1];
  logic [PATTERN_LEN-1:0] rows_d [MAX_EDITS+1];
  logic [PATTERN_LEN-1:0] match;

  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      match[i] = step_i.base_valid &&
                 (pattern_i[apdm_pkg::CodeW*i +: apdm_pkg::CodeW] == step_i.code);
    end
  end

  // match / substitution / insertion from the previous rows, deletion from the
  // row just built one edit lower
  always_comb begin
    rows_d[0] = {rows_q[0][PATTERN_LEN-2:0], 1'b1} & match;
    for (int j = 1; j <= MAX_EDITS; j++) begin
      rows_d[j] = ({rows_q[j][PATTERN_LEN-2:0], 1'b0} & match)
                | ({rows_q[j-1][PATTERN_LEN-2:0], 1'b0} & ~match)
                | rows_q[j-1]
                | {rows_d[j-1][PATTERN_LEN-2:0], 1'b0}
                | {{(PATTERN_LEN-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    flags_o[0] = rows_d[0][PATTERN_LEN-1];
    for (int j = 1; j <= MAX_EDITS; j++) begin
      flags_o[j] = rows_d[j][PATTERN_LEN-1] & ~rows_d[j-1][PATTERN_LEN-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= MAX_EDITS; j++) begin
        rows_q[j] <= '0;
      end
    end else if (step_i.update) begin
      for (int j = 0; j <= MAX_EDITS; j++) begin
        rows_q[j] <= rows_d[j];
      end
    end
  end

endmodule

@@ design/approx_dna_pattern_matcher.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   base_code_i, base_valid_i
// out       output     out_valid_o / out_stall_i end_flags_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item per cycle unless a held result stalls; the result is registered.
// The row update for all patterns and edit counts is one combinational step
// between the input register and the result register.
// Reset clears the pattern registers, the stored rows and both valid flags.
// A held result stalls the input only once the input register is also full.
module approx_dna_pattern_matcher #(
  parameter int unsigned PATTERN_LEN = apdm_pkg::PatternLenDef,
  parameter int unsigned MAX_EDITS   = apdm_pkg::MaxEditsDef,
  parameter int unsigned GROUP       = apdm_pkg::GroupDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [apdm_pkg::CodeW-1:0]   base_code_i,
  input  logic                         base_valid_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [apdm_pkg::FlagsW-1:0]  end_flags_o,
  input  logic                         cfg_we_i,
  input  logic [apdm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [apdm_pkg::CfgW-1:0]    cfg_data_i
);

  logic [apdm_pkg::CfgW-1:0] pat_q [apdm_pkg::NumPatReg];

  logic                       in_vld_q;
  logic [apdm_pkg::CodeW-1:0] code_q;
  logic                       bval_q;
  logic                       out_vld_q;
  logic [apdm_pkg::FlagsW-1:0] flags_q;
  logic [apdm_pkg::FlagsW-1:0] flags_d;

  logic in_acc;
  logic adv;
  apdm_pkg::step_t step;

  logic [MAX_EDITS:0] grp_flags [GROUP];
  logic [MAX_EDITS:0] any_flags;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < apdm_pkg::NumPatReg; r++) begin
        pat_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        apdm_pkg::RegPatternA: pat_q[0] <= cfg_data_i;
        apdm_pkg::RegPatternB: pat_q[1] <= cfg_data_i;
        apdm_pkg::RegPatternC: pat_q[2] <= cfg_data_i;
        apdm_pkg::RegPatternD: pat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= base_code_i;
      bval_q <= base_valid_i;
    end
    if (adv) begin
      flags_q <= flags_d;
    end
  end

  assign step.code       = code_q;
  assign step.base_valid = bval_q;
  assign step.update     = adv;

  for (genvar g = 0; g < GROUP; g++) begin : g_grp
    apdm_row_unit #(
      .PATTERN_LEN(PATTERN_LEN),
      .MAX_EDITS  (MAX_EDITS)
    ) u_row (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .pattern_i(pat_q[g][2*PATTERN_LEN-1:0]),
      .flags_o  (grp_flags[g])
    );
  end

  always_comb begin
    any_flags = '0;
    for (int g = 0; g < GROUP; g++) begin
      any_flags = any_flags | grp_flags[g];
    end
  end

  // edit counts beyond the output width are dropped
  for (genvar k = 0; k < apdm_pkg::FlagsW; k++) begin : g_flag
    if (k <= MAX_EDITS) begin : g_used
      assign flags_d[k] = any_flags[k];
    end else begin : g_zero
      assign flags_d[k] = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign end_flags_o = flags_q;

endmodule

@@ design/apdm_checker.sv @@
module apdm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [apdm_pkg::FlagsW-1:0]  end_flags_o
);

  // held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(end_flags_o))
    else $error("held result changed");

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // an accepted transaction reaches the output once the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !(out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

bind approx_dna_pattern_matcher apdm_checker u_apdm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .end_flags_o(end_flags_o)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PatLen  = apdm_pkg::PatternLenDef;
  localparam int unsigned MaxEd   = apdm_pkg::MaxEditsDef;
  localparam int unsigned NumPat  = apdm_pkg::GroupDef;

  localparam int unsigned CodeW     = apdm_pkg::CodeW;
  localparam int unsigned FlagsW    = apdm_pkg::FlagsW;
  localparam int unsigned CfgW      = apdm_pkg::CfgW;
  localparam int unsigned CfgIdxW   = apdm_pkg::CfgIdxW;
  localparam int unsigned NumPatReg = apdm_pkg::NumPatReg;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned CycleLimit    = 400000;

  localparam logic [CodeW-1:0] BaseA = 2'd0;
  localparam logic [CodeW-1:0] BaseC = 2'd1;
  localparam logic [CodeW-1:0] BaseT = 2'd2;
  localparam logic [CodeW-1:0] BaseG = 2'd3;

  localparam logic [CfgIdxW-1:0] PatReg [NumPatReg] = '{
    apdm_pkg::RegPatternA, apdm_pkg::RegPatternB, apdm_pkg::RegPatternC,
    apdm_pkg::RegPatternD
  };

  typedef enum logic [1:0] {StallNone, StallRandom, StallPeriodic, StallLong} stall_mode_e;
  typedef enum logic [1:0] {EditSubst, EditInsert, EditDelete} edit_kind_e;

  typedef struct packed {
    logic              typed;
    logic [FlagsW-1:0] flags;
    logic              ok;
    logic [CodeW-1:0]  code;
  } text_row_t;

  // first rows right after reset: nothing can reach the top pattern position yet
  localparam text_row_t DirectedRows [24] = '{
    '{1'b1, 4'h0, 1'b1, BaseA}, '{1'b1, 4'h0, 1'b1, BaseA},
    '{1'b1, 4'h0, 1'b1, BaseC}, '{1'b1, 4'h0, 1'b0, BaseA},
    '{1'b0, 4'h0, 1'b1, BaseT}, '{1'b0, 4'h0, 1'b1, BaseG},
    '{1'b0, 4'h0, 1'b0, BaseG}, '{1'b0, 4'h0, 1'b0, BaseC},
    '{1'b0, 4'h0, 1'b0, BaseT}, '{1'b0, 4'h0, 1'b1, BaseA},
    '{1'b0, 4'h0, 1'b1, BaseC}, '{1'b0, 4'h0, 1'b1, BaseT},
    '{1'b0, 4'h0, 1'b1, BaseG}, '{1'b0, 4'h0, 1'b1, BaseA},
    '{1'b0, 4'h0, 1'b1, BaseC}, '{1'b0, 4'h0, 1'b1, BaseT},
    '{1'b0, 4'h0, 1'b1, BaseG}, '{1'b0, 4'h0, 1'b1, BaseG},
    '{1'b0, 4'h0, 1'b1, BaseG}, '{1'b0, 4'h0, 1'b0, BaseA},
    '{1'b0, 4'h0, 1'b1, BaseA}, '{1'b0, 4'h0, 1'b1, BaseA},
    '{1'b0, 4'h0, 1'b1, BaseC}, '{1'b0, 4'h0, 1'b0, BaseG}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid  = 1'b0;
  logic               in_stall_o;
  logic [CodeW-1:0]   base_code = '0;
  logic               base_ok   = 1'b0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [FlagsW-1:0]  end_flags_o;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  // model state
  logic [CfgW-1:0]   pattern_q  [NumPatReg];
  logic [PatLen-1:0] prev_rows  [NumPat][MaxEd+1];
  logic [FlagsW-1:0] expected_flags_q [$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned bases_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned burst_left    = 0;
  int unsigned flag_seen [FlagsW];
  logic [7:0]  stall_cnt     = '0;
  stall_mode_e stall_mode    = StallNone;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  approx_dna_pattern_matcher i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .base_code_i  (base_code),
    .base_valid_i (base_ok),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .end_flags_o  (end_flags_o),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Advance every pattern's rows by one text base; returns the end flags.
  function automatic logic [FlagsW-1:0] advance_rows(input logic [CodeW-1:0] code,
                                                      input logic ok);
    logic [PatLen-1:0] hits;
    logic [PatLen-1:0] row [MaxEd+1];
    logic [FlagsW-1:0] flags;
    flags = '0;
    for (int g = 0; g < NumPat; g++) begin
      for (int i = 0; i < PatLen; i++) begin
        hits[i] = ok && (pattern_q[g % NumPatReg][2*i +: CodeW] == code);
      end
      row[0] = ((prev_rows[g][0] << 1) | PatLen'(1)) & hits;
      for (int j = 1; j <= MaxEd; j++) begin
        row[j] = ((prev_rows[g][j] << 1) & hits)
               | ((prev_rows[g][j-1] << 1) & ~hits)
               | prev_rows[g][j-1]
               | (row[j-1] << 1)
               | PatLen'(1);
      end
      if (row[0][PatLen-1]) flags[0] = 1'b1;
      for (int j = 1; j <= MaxEd; j++) begin
        // counts above the flag width are dropped
        if (j < FlagsW && row[j][PatLen-1] && !row[j-1][PatLen-1]) flags[j] = 1'b1;
      end
      for (int j = 0; j <= MaxEd; j++) prev_rows[g][j] = row[j];
    end
    return flags;
  endfunction

  task automatic send_base(input logic [CodeW-1:0] code, input logic ok,
                           input logic typed, input logic [FlagsW-1:0] typed_flags);
    int unsigned gap;
    logic [FlagsW-1:0] predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    base_code <= code;
    base_ok   <= ok;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_rows(code, ok);
    expected_flags_q.push_back(typed ? typed_flags : predicted);
    bases_sent++;
  endtask

  task automatic write_pattern(input int unsigned g, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= PatReg[g];
    cfg_data  <= value;
    @(posedge clk_i);
    pattern_q[g] = value;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Pattern copy with a handful of edits, so that the rows reach the top position.
  task automatic send_edited_copy(input int unsigned g);
    logic [CodeW:0] text_q [$];
    int unsigned n_edits;
    int unsigned pos;
    edit_kind_e kind;
    for (int i = 0; i < PatLen; i++) text_q.push_back({1'b1, pattern_q[g][2*i +: CodeW]});
    n_edits = $urandom_range(0, MaxEd + 1);
    repeat (n_edits) begin
      kind = edit_kind_e'($urandom_range(0, 2));
      pos  = $urandom_range(0, text_q.size() - 1);
      case (kind)
        EditSubst: begin
          text_q[pos] = {($urandom_range(0, 3) != 0), CodeW'($urandom_range(0, 3))};
        end
        EditInsert: begin
          text_q.insert(pos, {1'b1, CodeW'($urandom_range(0, 3))});
        end
        default: begin
          text_q.delete(pos);
        end
      endcase
    end
    foreach (text_q[i]) send_base(text_q[i][CodeW-1:0], text_q[i][CodeW], 1'b0, '0);
  endtask

  // Receiver stall: a new random stall pattern is picked whenever the 8-bit stall_cnt wraps.
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt == 8'hff) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:     out_stall <= 1'b0;
      StallRandom:   out_stall <= ($urandom_range(0, 2) == 0);
      StallPeriodic: out_stall <= (stall_cnt[2:0] == 3'd5);
      default:       out_stall <= (stall_cnt[4:3] == 2'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_flags_q.size() == 0) begin
        $error("end_flags: unexpected transaction, got %h", end_flags_o);
        error_count++;
      end else begin
        if (end_flags_o !== expected_flags_q[0]) begin
          $error("end_flags mismatch: expected %h, got %h", expected_flags_q[0], end_flags_o);
          error_count++;
        end
        void'(expected_flags_q.pop_front());
      end
      results_seen++;
      for (int j = 0; j < FlagsW; j++) if (end_flags_o[j]) flag_seen[j]++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase_items;
    logic [CfgW-1:0] value;
    foreach (pattern_q[g]) pattern_q[g] = '0;
    foreach (prev_rows[g, j]) prev_rows[g][j] = '0;
    foreach (flag_seen[j]) flag_seen[j] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all A, all G, ACTG repeated, all C
    write_pattern(0, '0);
    write_pattern(1, '1);
    write_pattern(2, {8{8'he4}});
    write_pattern(3, {32{2'b01}});
    cfg_we <= 1'b0;

    foreach (DirectedRows[r]) begin
      send_base(DirectedRows[r].code, DirectedRows[r].ok, DirectedRows[r].typed,
                DirectedRows[r].flags);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      // rows are kept across a pattern change
      for (int g = 0; g < NumPatReg; g++) begin
        if (p == NumPhases - 1) begin
          value = '1;
        end else if ($urandom_range(0, 2) != 0 || g == p % NumPatReg) begin
          case ($urandom_range(0, 5))
            0:       value = '0;
            1:       value = '1;
            2:       value = {32{2'b10}};
            3:       value = {8{8'($urandom)}};
            default: value = {$urandom, $urandom};
          endcase
        end else begin
          continue;
        end
        write_pattern(g, value);
      end
      cfg_we <= 1'b0;

      phase_items = bases_sent;
      while (bases_sent - phase_items < ItemsPerPhase) begin
        if ($urandom_range(0, 9) < 7) begin
          send_edited_copy($urandom_range(0, NumPatReg - 1));
        end else begin
          repeat ($urandom_range(1, 10)) begin
            send_base(CodeW'($urandom_range(0, 3)), ($urandom_range(0, 5) != 0), 1'b0, '0);
          end
        end
      end
    end

    wait_idle();
    $display("Sent %0d text bases over %0d pattern settings, checked %0d results",
             bases_sent, NumPhases + 1, results_seen);
    $display("End flags raised for 0/1/2/3 edits: %0d / %0d / %0d / %0d",
             flag_seen[0], flag_seen[1], flag_seen[2], flag_seen[3]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/apdm_pkg.sv
design/apdm_row_unit.sv
design/approx_dna_pattern_matcher.sv
design/apdm_checker.sv
verif/testbench.sv
